// File: rtl/core/psc_pkg.sv
// Shared types and constants for the PID speed controller.
// Depends on nothing; imported by psc_mul, psc_div and pid_speed_controller.
package psc_pkg;

  // Input request and result payloads
  typedef struct packed {
    logic               command;
    logic signed [15:0] target;
    logic signed [15:0] sensed;
    logic        [15:0] elapsed_ms;
  } psc_in_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               held;
  } psc_out_t;

  // Operand widths of the shared shift-add multiplier and restoring divider
  localparam int MA_W = 48;
  localparam int MB_W = 32;
  localparam int DV_W = 10;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_cmd_t;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] num;
    logic [DV_W-1:0] den;
  } div_cmd_t;

  // Command codes
  localparam logic CMD_COMPUTE = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_GAIN_P      = 3'd0;
  localparam logic [2:0] REG_GAIN_I      = 3'd1;
  localparam logic [2:0] REG_GAIN_D      = 3'd2;
  localparam logic [2:0] REG_DRIVE_LIMIT = 3'd3;
  localparam logic [2:0] REG_ACCUM_LIMIT = 3'd4;
  localparam logic [2:0] REG_SMOOTH_COEF = 3'd5;
  localparam logic [2:0] REG_DEAD_ZONE   = 3'd6;
  localparam logic [2:0] REG_MAX_STEP    = 3'd7;

  // Time window and scaling
  localparam logic [15:0]     DT_MIN_MS = 16'd20;
  localparam logic [15:0]     DT_MAX_MS = 16'd200;
  localparam logic [DV_W-1:0] MS_PER_S  = 10'd1000;

endpackage

// File: rtl/core/psc_mul.sv
// Shift-add multiplier: one multiplier bit per cycle, stops once the bits run out.
// Depends on psc_pkg (mul_cmd_t, operand widths).
module psc_mul import psc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  mul_cmd_t        cmd,
  output logic            busy,
  output logic            done,
  output logic [MA_W-1:0] prod
);

  logic [MA_W-1:0] a_r;
  logic [MB_W-1:0] b_r;
  logic [MA_W-1:0] acc_r;
  logic            busy_r;
  logic            done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        a_r    <= cmd.a;
        b_r    <= cmd.b;
        acc_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (b_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (b_r[0]) begin
            acc_r <= acc_r + a_r;
          end
          a_r <= a_r << 1;
          b_r <= b_r >> 1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: rtl/core/psc_div.sv
// Restoring divider: one quotient bit per cycle over the full dividend width.
// Depends on psc_pkg (div_cmd_t, operand widths).
module psc_div import psc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  div_cmd_t        cmd,
  output logic            busy,
  output logic            done,
  output logic [MA_W-1:0] quo
);

  localparam int CW = $clog2(MA_W);
  localparam logic [CW-1:0] LAST = CW'(MA_W - 1);

  logic [MA_W-1:0] q_r;
  logic [DV_W-1:0] rem_r;
  logic [DV_W-1:0] den_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [DV_W:0] rem_sh;
  logic [DV_W:0] diff;
  logic          ge;

  always_comb begin
    rem_sh = {rem_r, q_r[MA_W-1]};
    diff   = rem_sh - {1'b0, den_r};
    ge     = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        q_r    <= cmd.num;
        rem_r  <= '0;
        den_r  <= cmd.den;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r   <= {q_r[MA_W-2:0], ge};
        rem_r <= ge ? diff[DV_W-1:0] : rem_sh[DV_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;

endmodule

// File: rtl/core/pid_speed_controller.sv
// PID speed controller, top level: sequencer, registers and state.
// Depends on psc_pkg, psc_mul and psc_div.
// Sequence: a reset command or an out-of-window time step goes from S_IDLE to
// S_OUT and on to the output register; a compute request passes through up to
// three divisions and up to six passes through the shift-add multiplier.
// Throughput: one request at a time; the next is taken as soon as the result
// is in the output register. Reset (rst_n low, synchronous) loads the register
// defaults and clears the integral, last measurement and last drive.
module pid_speed_controller import psc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  psc_in_t     in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output psc_out_t    out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = 50;  // signed width of the term sums
  localparam int FW = 29;  // signed width of the filter products

  typedef enum logic [4:0] {
    S_IDLE, S_PMUL, S_IPMUL, S_IPDIV, S_CHK, S_EMUL, S_IMS, S_IMUL, S_IDIV,
    S_DMUL1, S_DMUL2, S_DDIV, S_SUM, S_RND, S_RATE, S_FILT1, S_FILT2, S_FRND,
    S_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [15:0] gain_p_r, gain_i_r, gain_d_r, max_step_r;
  logic [14:0] drive_limit_r, dead_zone_r;
  logic [30:0] accum_limit_r;
  logic [8:0]  smooth_coef_r;

  // controller state
  logic signed [31:0] accum_r;
  logic signed [15:0] last_sensed_r;
  logic signed [15:0] last_drive_r;

  // working registers for the request in flight
  psc_in_t            in_r;
  logic               err_neg_r;
  logic [15:0]        err_mag_r;
  logic               clr_r, upd_r;
  logic signed [SW-1:0] p_r, ipre_r, ival_r, d_r;
  logic signed [24:0] s_r;
  logic signed [17:0] v_r, r_r;
  logic signed [FW-1:0] t1_r, fnum_r;
  psc_out_t           res_r;
  logic               out_valid_r;
  psc_out_t           out_data_r;

  mul_cmd_t           mul_cmd_r;
  div_cmd_t           div_cmd_r;
  logic               mul_busy, mul_done, div_busy, div_done;
  logic [MA_W-1:0]    prod, quo;

  psc_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (mul_cmd_r),
    .busy (mul_busy),
    .done (mul_done),
    .prod (prod)
  );

  psc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (div_cmd_r),
    .busy (div_busy),
    .done (div_done),
    .quo  (quo)
  );

  // ---- combinational helpers ----
  logic               cfg_wr;
  logic               dt_ok;
  logic signed [16:0] err_raw;
  logic [16:0]        err_abs;
  logic               err_neg_nxt;
  logic [15:0]        err_mag_nxt;
  logic [31:0]        accum_mag;
  logic signed [16:0] ds;
  logic               ds_neg;
  logic [15:0]        ds_mag;
  logic signed [SW-1:0] prod_s, quo_s, lim_s, pi_sum, s_sum;
  logic               windup_blk;
  logic signed [33:0] acc_sum, alim_s, acc_nxt;
  logic signed [24:0] lim25;
  logic [23:0]        s_abs;
  logic [15:0]        v_mag;
  logic signed [17:0] lo, hi;
  logic [8:0]         coef;
  logic signed [FW-1:0] c_s, cm_s, ld_s, r_s;
  logic [FW-1:0]      f_abs;
  logic [FW-1:0]      f_mag;
  logic signed [15:0] f_nxt;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    // time window and deadband on the incoming request
    dt_ok       = (in_data.elapsed_ms > DT_MIN_MS) && (in_data.elapsed_ms <= DT_MAX_MS);
    err_raw     = 17'(in_data.target) - 17'(in_data.sensed);
    err_abs     = err_raw[16] ? 17'(-err_raw) : err_raw;
    if (err_abs < {2'b00, dead_zone_r}) begin
      err_neg_nxt = 1'b0;
      err_mag_nxt = '0;
    end else begin
      err_neg_nxt = err_raw[16];
      err_mag_nxt = err_abs[15:0];
    end

    accum_mag = accum_r[31] ? 32'(-accum_r) : 32'(accum_r);

    ds     = 17'(in_r.sensed) - 17'(last_sensed_r);
    ds_neg = ds[16];
    ds_mag = ds_neg ? 16'(-ds) : ds[15:0];

    prod_s = $signed({2'b00, prod});
    quo_s  = $signed({2'b00, quo});
    lim_s  = $signed(SW'({drive_limit_r, 8'h00}));

    // anti-windup: hold the integral while it would push deeper into saturation
    pi_sum     = p_r + ipre_r;
    windup_blk = ((pi_sum >= lim_s) && !err_neg_r && (err_mag_r != '0)) ||
                 ((pi_sum <= -lim_s) && err_neg_r);

    alim_s  = $signed({3'b000, accum_limit_r});
    acc_sum = 34'(accum_r) + (err_neg_r ? -$signed({1'b0, prod[32:0]})
                                        : $signed({1'b0, prod[32:0]}));
    if (acc_sum > alim_s) begin
      acc_nxt = alim_s;
    end else if (acc_sum < -alim_s) begin
      acc_nxt = -alim_s;
    end else begin
      acc_nxt = acc_sum;
    end

    // sum and clamp to the drive limit
    lim25 = $signed({2'b00, drive_limit_r, 8'h00});
    s_sum = p_r + ival_r + d_r;
    s_abs = s_r[24] ? 24'(-s_r) : s_r[23:0];
    v_mag = 16'((25'(s_abs) + 25'd128) >> 8);

    lo = 18'(last_drive_r) - $signed({2'b00, max_step_r});
    hi = 18'(last_drive_r) + $signed({2'b00, max_step_r});

    // low-pass filter operands
    coef  = (smooth_coef_r > 9'd256) ? 9'd256 : smooth_coef_r;
    c_s   = $signed(FW'(coef));
    cm_s  = $signed(FW'(10'd256 - {1'b0, coef}));
    ld_s  = FW'(last_drive_r);
    r_s   = FW'(r_r);
    f_abs = fnum_r[FW-1] ? FW'(-fnum_r) : FW'(fnum_r);
    f_mag = (f_abs + FW'(128)) >> 8;
    f_nxt = fnum_r[FW-1] ? 16'(-$signed(f_mag)) : 16'(f_mag);
  end

  // ---- register read ----
  always_comb begin
    case (paddr[4:2])
      REG_GAIN_P:      prdata = 32'(gain_p_r);
      REG_GAIN_I:      prdata = 32'(gain_i_r);
      REG_GAIN_D:      prdata = 32'(gain_d_r);
      REG_DRIVE_LIMIT: prdata = 32'(drive_limit_r);
      REG_ACCUM_LIMIT: prdata = 32'(accum_limit_r);
      REG_SMOOTH_COEF: prdata = 32'(smooth_coef_r);
      REG_DEAD_ZONE:   prdata = 32'(dead_zone_r);
      REG_MAX_STEP:    prdata = 32'(max_step_r);
      default:         prdata = '0;
    endcase
  end

  // ---- sequencer, state and registered outputs ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      mul_cmd_r.start <= 1'b0;
      div_cmd_r.start <= 1'b0;
      accum_r         <= '0;
      last_sensed_r   <= '0;
      last_drive_r    <= '0;
      gain_p_r        <= 16'd256;
      gain_i_r        <= '0;
      gain_d_r        <= '0;
      drive_limit_r   <= 15'h7fff;
      accum_limit_r   <= 31'h7fffffff;
      smooth_coef_r   <= '0;
      dead_zone_r     <= '0;
      max_step_r      <= 16'hffff;
    end else begin
      // start pulses last one cycle; no unit is restarted while its pulse is high
      if (mul_cmd_r.start) begin
        mul_cmd_r.start <= 1'b0;
      end
      if (div_cmd_r.start) begin
        div_cmd_r.start <= 1'b0;
      end

      if (cfg_wr) begin
        case (paddr[4:2])
          REG_GAIN_P:      gain_p_r      <= pwdata[15:0];
          REG_GAIN_I:      gain_i_r      <= pwdata[15:0];
          REG_GAIN_D:      gain_d_r      <= pwdata[15:0];
          REG_DRIVE_LIMIT: drive_limit_r <= pwdata[14:0];
          REG_ACCUM_LIMIT: accum_limit_r <= pwdata[30:0];
          REG_SMOOTH_COEF: smooth_coef_r <= pwdata[8:0];
          REG_DEAD_ZONE:   dead_zone_r   <= pwdata[14:0];
          REG_MAX_STEP:    max_step_r    <= pwdata[15:0];
          default:         ;
        endcase
      end

      // drop the result once taken, unless a new one replaces it this cycle
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r <= in_data;
            if (in_data.command == CMD_CLEAR) begin
              res_r   <= '{drive: 16'sd0, held: 1'b0};
              clr_r   <= 1'b1;
              upd_r   <= 1'b0;
              state_r <= S_OUT;
            end else if (!dt_ok) begin
              // hold the previous output, touch no state
              res_r   <= '{drive: last_drive_r, held: 1'b1};
              clr_r   <= 1'b0;
              upd_r   <= 1'b0;
              state_r <= S_OUT;
            end else begin
              err_neg_r <= err_neg_nxt;
              err_mag_r <= err_mag_nxt;
              clr_r     <= 1'b0;
              upd_r     <= 1'b1;
              mul_cmd_r <= '{start: 1'b1, a: MA_W'(gain_p_r), b: MB_W'(err_mag_nxt)};
              state_r   <= S_PMUL;
            end
          end
        end
        S_PMUL: begin
          if (mul_done) begin
            p_r       <= err_neg_r ? -prod_s : prod_s;
            mul_cmd_r <= '{start: 1'b1, a: MA_W'(gain_i_r), b: accum_mag};
            state_r   <= S_IPMUL;
          end
        end
        S_IPMUL: begin
          if (mul_done) begin
            div_cmd_r <= '{start: 1'b1, num: prod, den: MS_PER_S};
            state_r   <= S_IPDIV;
          end
        end
        S_IPDIV: begin
          if (div_done) begin
            ipre_r  <= accum_r[31] ? -quo_s : quo_s;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (windup_blk) begin
            // integral unchanged: reuse the term already computed
            ival_r    <= ipre_r;
            mul_cmd_r <= '{start: 1'b1, a: MA_W'(gain_d_r), b: MB_W'(ds_mag)};
            state_r   <= S_DMUL1;
          end else begin
            mul_cmd_r <= '{start: 1'b1, a: MA_W'(err_mag_r),
                           b: MB_W'(in_r.elapsed_ms)};
            state_r   <= S_EMUL;
          end
        end
        S_EMUL: begin
          if (mul_done) begin
            accum_r <= acc_nxt[31:0];
            state_r <= S_IMS;
          end
        end
        S_IMS: begin
          mul_cmd_r <= '{start: 1'b1, a: MA_W'(gain_i_r), b: accum_mag};
          state_r   <= S_IMUL;
        end
        S_IMUL: begin
          if (mul_done) begin
            div_cmd_r <= '{start: 1'b1, num: prod, den: MS_PER_S};
            state_r   <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (div_done) begin
            ival_r    <= accum_r[31] ? -quo_s : quo_s;
            mul_cmd_r <= '{start: 1'b1, a: MA_W'(gain_d_r), b: MB_W'(ds_mag)};
            state_r   <= S_DMUL1;
          end
        end
        S_DMUL1: begin
          if (mul_done) begin
            mul_cmd_r <= '{start: 1'b1, a: prod, b: MB_W'(MS_PER_S)};
            state_r   <= S_DMUL2;
          end
        end
        S_DMUL2: begin
          if (mul_done) begin
            div_cmd_r <= '{start: 1'b1, num: prod,
                           den: in_r.elapsed_ms[DV_W-1:0]};
            state_r   <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (div_done) begin
            // derivative on measurement enters with negative sign
            d_r     <= ds_neg ? quo_s : -quo_s;
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          if (s_sum > lim_s) begin
            s_r <= lim25;
          end else if (s_sum < -lim_s) begin
            s_r <= -lim25;
          end else begin
            s_r <= s_sum[24:0];
          end
          state_r <= S_RND;
        end
        S_RND: begin
          v_r     <= s_r[24] ? -$signed({2'b00, v_mag}) : $signed({2'b00, v_mag});
          state_r <= S_RATE;
        end
        S_RATE: begin
          if (v_r > hi) begin
            r_r <= hi;
          end else if (v_r < lo) begin
            r_r <= lo;
          end else begin
            r_r <= v_r;
          end
          state_r <= S_FILT1;
        end
        S_FILT1: begin
          t1_r    <= c_s * ld_s;
          state_r <= S_FILT2;
        end
        S_FILT2: begin
          fnum_r  <= t1_r + cm_s * r_s;
          state_r <= S_FRND;
        end
        S_FRND: begin
          res_r   <= '{drive: f_nxt, held: 1'b0};
          state_r <= S_OUT;
        end
        S_OUT: begin
          // advance once the output register is free; commit state with it
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            if (clr_r) begin
              accum_r       <= '0;
              last_sensed_r <= '0;
              last_drive_r  <= '0;
            end
            if (upd_r) begin
              last_drive_r  <= res_r.drive;
              last_sensed_r <= in_r.sensed;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- assertions ----
  a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!mul_busy && !div_busy))
    else $error("arithmetic unit busy while sequencer idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted request did not start the sequencer");

  a_held_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.held) |-> (out_data.drive == last_drive_r))
    else $error("held result differs from stored drive");

endmodule
